@@ rtl/core/rpi_pkg.sv @@
// rpi_pkg: widths, register indexes and shared types for the ray/plane block
// depends on nothing; imported by every module under rtl/core
package rpi_pkg;

  // coordinate format
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths of the exact intermediate values
  localparam int DIFF_W = COORD_BITS + 1;       // plane point minus origin
  localparam int PN_W   = 2 * COORD_BITS + 1;   // diff times normal
  localparam int PD_W   = 2 * COORD_BITS;       // dir times normal, dir squared
  localparam int NUM_W  = 2 * COORD_BITS + 2;   // signed numerator sum
  localparam int NMAG_W = 2 * COORD_BITS + 1;   // numerator magnitude
  localparam int DEN_W  = 2 * COORD_BITS + 1;   // signed denominator sum
  localparam int DMAG_W = 2 * COORD_BITS;       // denominator magnitude
  localparam int SQ_W   = 2 * COORD_BITS;       // squared direction length
  localparam int ROOT_W = COORD_BITS;           // truncated direction length
  localparam int REM_W  = ROOT_W + 2;           // square root remainder
  localparam int X_W    = NMAG_W + ROOT_W;      // dividend

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;

  // normal_z comes out of reset as 1.0
  localparam logic [COORD_BITS-1:0] NORMAL_Z_RESET = COORD_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] pz;
    logic [COORD_BITS-1:0] nx;
    logic [COORD_BITS-1:0] ny;
    logic [COORD_BITS-1:0] nz;
  } rpi_plane_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [COORD_BITS-1:0] oz;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] dz;
  } rpi_ray_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              hit;
    logic [NMAG_W-1:0] nmag;
    logic [DMAG_W-1:0] dmag;
    logic [SQ_W-1:0]   sq;
  } rpi_work_t;

endpackage

@@ rtl/core/rpi_front.sv @@
// rpi_front: dot products of one ray against the plane and hit classification
// depends on rpi_pkg; feeds rpi_queue
module rpi_front import rpi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rpi_plane_t plane,
  input  rpi_ray_t   ray,
  input  logic       in_valid,
  output logic       in_ready,
  output rpi_work_t  work,
  output logic       work_valid,
  input  logic       work_ready
);

  logic signed [COORD_BITS-1:0] o [3];
  logic signed [COORD_BITS-1:0] d [3];
  logic signed [COORD_BITS-1:0] p [3];
  logic signed [COORD_BITS-1:0] n [3];
  logic signed [DIFF_W-1:0]     diff [3];
  logic signed [PN_W-1:0]       pn_next [3];
  logic signed [PD_W-1:0]       dn_next [3];
  logic signed [PD_W-1:0]       dd_next [3];
  logic signed [PN_W-1:0]       pn [3];
  logic signed [PD_W-1:0]       dn [3];
  logic [SQ_W-1:0]              dd [3];
  logic                         s1_valid;
  logic signed [NUM_W-1:0]      num;
  logic signed [DEN_W-1:0]      den;

  assign o[0] = $signed(ray.ox);
  assign o[1] = $signed(ray.oy);
  assign o[2] = $signed(ray.oz);
  assign d[0] = $signed(ray.dx);
  assign d[1] = $signed(ray.dy);
  assign d[2] = $signed(ray.dz);
  assign p[0] = $signed(plane.px);
  assign p[1] = $signed(plane.py);
  assign p[2] = $signed(plane.pz);
  assign n[0] = $signed(plane.nx);
  assign n[1] = $signed(plane.ny);
  assign n[2] = $signed(plane.nz);

  // per-axis products, one multiplier per product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = DIFF_W'(p[i]) - DIFF_W'(o[i]);
      pn_next[i] = PN_W'(diff[i]) * PN_W'(n[i]);
      dn_next[i] = PD_W'(d[i]) * PD_W'(n[i]);
      dd_next[i] = PD_W'(d[i]) * PD_W'(d[i]);
    end
  end

  assign in_ready   = !s1_valid || work_ready;
  assign work_valid = s1_valid;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        pn[i] <= pn_next[i];
        dn[i] <= dn_next[i];
        dd[i] <= SQ_W'(dd_next[i]);
      end
    end
  end

  // sums and classification
  assign num = NUM_W'(pn[0]) + NUM_W'(pn[1]) + NUM_W'(pn[2]);
  assign den = DEN_W'(dn[0]) + DEN_W'(dn[1]) + DEN_W'(dn[2]);

  always_comb begin
    work.hit  = (den != '0) && ((num == '0) || (num[NUM_W-1] == den[DEN_W-1]));
    work.nmag = num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
    work.dmag = den[DEN_W-1] ? DMAG_W'(-den) : DMAG_W'(den);
    work.sq   = dd[0] + dd[1] + dd[2];
  end

endmodule

@@ rtl/core/rpi_queue.sv @@
// rpi_queue: short fifo of classified items between front and back
// depends on rpi_pkg
module rpi_queue import rpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rpi_work_t wr_data,
  input  logic      wr_valid,
  output logic      wr_ready,
  output rpi_work_t rd_data,
  output logic      rd_valid,
  input  logic      rd_ready
);

  rpi_work_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign wr_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

endmodule

@@ rtl/core/rpi_back.sv @@
// rpi_back: pipelined square root, scaling multiply and restoring divide
// depends on rpi_pkg; drains rpi_queue and holds the output register
module rpi_back import rpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  rpi_work_t             work,
  input  logic                  work_valid,
  output logic                  work_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [COORD_BITS-1:0] distance,
  output logic                  saturated
);

  logic en;

  // square root stages
  logic              s_v    [ROOT_W];
  logic [REM_W-1:0]  s_rem  [ROOT_W];
  logic [ROOT_W-1:0] s_root [ROOT_W];
  logic [SQ_W-1:0]   s_sq   [ROOT_W];
  logic              s_hit  [ROOT_W];
  logic [NMAG_W-1:0] s_nmag [ROOT_W];
  logic [DMAG_W-1:0] s_dmag [ROOT_W];

  // multiply and add stages
  logic              m_v;
  logic              m_hit;
  logic [DMAG_W-1:0] m_dmag;
  logic [PD_W-1:0]   m_lo;
  logic [PD_W:0]     m_hi;
  logic              a_v;
  logic              a_hit;
  logic              a_sat;
  logic [DMAG_W-1:0] a_dmag;
  logic [X_W-1:0]    a_x;
  logic [X_W-1:0]    x_sum;

  // divide stages
  logic                  v_v    [COORD_BITS];
  logic                  v_hit  [COORD_BITS];
  logic                  v_sat  [COORD_BITS];
  logic [DMAG_W-1:0]     v_dmag [COORD_BITS];
  logic [X_W-1:0]        v_rem  [COORD_BITS];
  logic [COORD_BITS-1:0] v_q    [COORD_BITS];

  // whole back part advances while the output register can take an item
  assign en         = !out_valid || out_ready;
  assign work_ready = en;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic              c_v;
    logic [REM_W-1:0]  c_rem;
    logic [ROOT_W-1:0] c_root;
    logic [SQ_W-1:0]   c_sq;
    logic              c_hit;
    logic [NMAG_W-1:0] c_nmag;
    logic [DMAG_W-1:0] c_dmag;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign c_v    = work_valid;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_sq   = work.sq;
      assign c_hit  = work.hit;
      assign c_nmag = work.nmag;
      assign c_dmag = work.dmag;
    end else begin : g_next
      assign c_v    = s_v[k-1];
      assign c_rem  = s_rem[k-1];
      assign c_root = s_root[k-1];
      assign c_sq   = s_sq[k-1];
      assign c_hit  = s_hit[k-1];
      assign c_nmag = s_nmag[k-1];
      assign c_dmag = s_dmag[k-1];
    end

    // one root bit: bring down two radicand bits, try (root << 2) | 1
    assign rem_sh = {c_rem[REM_W-3:0], c_sq[SQ_W-1 -: 2]};
    assign trial  = {c_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[k] <= 1'b0;
      end else if (en) begin
        s_v[k] <= c_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k]  <= ge ? rem_sh - trial : rem_sh;
        s_root[k] <= {c_root[ROOT_W-2:0], ge};
        s_sq[k]   <= c_sq << 2;
        s_hit[k]  <= c_hit;
        s_nmag[k] <= c_nmag;
        s_dmag[k] <= c_dmag;
      end
    end
  end

  // partial products of numerator magnitude times length
  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      a_v <= 1'b0;
    end else if (en) begin
      m_v <= s_v[ROOT_W-1];
      a_v <= m_v;
    end
  end

  assign x_sum = (X_W'(m_hi) << COORD_BITS) + X_W'(m_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit  <= s_hit[ROOT_W-1];
      m_dmag <= s_dmag[ROOT_W-1];
      m_lo   <= PD_W'(s_nmag[ROOT_W-1][COORD_BITS-1:0]) * PD_W'(s_root[ROOT_W-1]);
      m_hi   <= (PD_W+1)'(s_nmag[ROOT_W-1][NMAG_W-1:COORD_BITS])
              * (PD_W+1)'(s_root[ROOT_W-1]);
      // combine and check the quotient against the output range
      a_hit  <= m_hit;
      a_dmag <= m_dmag;
      a_x    <= x_sum;
      a_sat  <= x_sum >= (X_W'(m_dmag) << COORD_BITS);
    end
  end

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
    localparam int B = COORD_BITS - 1 - k;
    logic                  c_v;
    logic                  c_hit;
    logic                  c_sat;
    logic [DMAG_W-1:0]     c_dmag;
    logic [X_W-1:0]        c_rem;
    logic [COORD_BITS-1:0] c_q;
    logic [X_W-1:0]        shifted;
    logic                  ge;

    if (k == 0) begin : g_first
      assign c_v    = a_v;
      assign c_hit  = a_hit;
      assign c_sat  = a_sat;
      assign c_dmag = a_dmag;
      assign c_rem  = a_x;
      assign c_q    = '0;
    end else begin : g_next
      assign c_v    = v_v[k-1];
      assign c_hit  = v_hit[k-1];
      assign c_sat  = v_sat[k-1];
      assign c_dmag = v_dmag[k-1];
      assign c_rem  = v_rem[k-1];
      assign c_q    = v_q[k-1];
    end

    // one quotient bit: subtract the shifted divisor when it fits
    assign shifted = X_W'(c_dmag) << B;
    assign ge      = c_hit && !c_sat && (c_rem >= shifted);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_v[k] <= 1'b0;
      end else if (en) begin
        v_v[k] <= c_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_hit[k]  <= c_hit;
        v_sat[k]  <= c_sat;
        v_dmag[k] <= c_dmag;
        v_rem[k]  <= ge ? c_rem - shifted : c_rem;
        v_q[k]    <= {c_q[COORD_BITS-2:0], ge};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_v[COORD_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit       <= v_hit[COORD_BITS-1];
      saturated <= v_hit[COORD_BITS-1] && v_sat[COORD_BITS-1];
      if (!v_hit[COORD_BITS-1]) begin
        distance <= '0;
      end else if (v_sat[COORD_BITS-1]) begin
        distance <= '1;
      end else begin
        distance <= v_q[COORD_BITS-1];
      end
    end
  end

endmodule

@@ rtl/core/ray_plane_intersection.sv @@
// ray_plane_intersection: distance from a ray origin to a configured plane
// one item per cycle sustained while the output is not stalled; the back part holds
// the 32-stage square root and 32-stage divide pipelines
// a 4-entry queue parts front and back; an output stall halts the back part at once
// reset (synchronous) empties all stages, plane point 0, normal (0, 0, 1.0)
// depends on rpi_pkg, rpi_front, rpi_queue, rpi_back
module ray_plane_intersection import rpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] origin_z,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] dir_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [COORD_BITS-1:0] distance,
  output logic                  saturated
);

  rpi_plane_t plane;
  rpi_ray_t   ray;
  rpi_work_t  f_work;
  logic       f_valid;
  logic       f_ready;
  rpi_work_t  q_work;
  logic       q_valid;
  logic       q_ready;

  // plane registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '{px: '0, py: '0, pz: '0, nx: '0, ny: '0, nz: NORMAL_Z_RESET};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POINT_X:  plane.px <= cfg_data;
        REG_POINT_Y:  plane.py <= cfg_data;
        REG_POINT_Z:  plane.pz <= cfg_data;
        REG_NORMAL_X: plane.nx <= cfg_data;
        REG_NORMAL_Y: plane.ny <= cfg_data;
        REG_NORMAL_Z: plane.nz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ray = '{ox: origin_x, oy: origin_y, oz: origin_z,
                 dx: dir_x, dy: dir_y, dz: dir_z};

  rpi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .plane      (plane),
    .ray        (ray),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .work       (f_work),
    .work_valid (f_valid),
    .work_ready (f_ready)
  );

  rpi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_work),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_work),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  rpi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work       (q_work),
    .work_valid (q_valid),
    .work_ready (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .distance   (distance),
    .saturated  (saturated)
  );

`ifndef SYNTHESIS
  // a miss carries no distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0 && !saturated)
    else $error("miss with nonzero distance or saturation");

  // clamping always gives the full-scale distance
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> hit && distance == '1)
    else $error("saturated result not at full scale");

  // a classified item blocked by a full queue stays put
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_work))
    else $error("front item lost while queue full");
`endif

endmodule

@@ tb/ray_plane_intersection_tb.sv @@
// ray_plane_intersection_tb: self-checking testbench for the ray/plane distance block
// predicts every result with exact wide integer arithmetic and checks it field by field
// depends on rpi_pkg and ray_plane_intersection
`timescale 1ns / 1ps

module ray_plane_intersection_tb;
  import rpi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic                  hit;
    logic [COORD_BITS-1:0] distance;
    logic                  saturated;
  } ray_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_BITS-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [COORD_BITS-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [COORD_BITS-1:0] distance;
  logic saturated;

  rpi_ray_t    ray_backlog[$];
  ray_result_t hits_due[$];
  logic [COORD_BITS-1:0] plane_regs[6];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  ray_plane_intersection dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z,
    .out_valid, .out_ready, .hit, .distance, .saturated
  );

  always #1 clk = ~clk;

  // exact distance from ray origin to the configured plane
  function automatic ray_result_t trace_plane(rpi_ray_t r);
    logic signed [COORD_BITS-1:0] o[3], d[3], p[3], n[3];
    logic signed [131:0] numer, denom, sq;
    logic [63:0] root, cand;
    logic [127:0] cand_sq;
    logic [255:0] nmag, dmag, x, q;
    ray_result_t res;
    o = '{r.ox, r.oy, r.oz};
    d = '{r.dx, r.dy, r.dz};
    for (int i = 0; i < 3; i++) begin
      p[i] = plane_regs[i];
      n[i] = plane_regs[3 + i];
    end
    numer = '0;
    denom = '0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      numer += (132'(p[i]) - 132'(o[i])) * 132'(n[i]);
      denom += 132'(d[i]) * 132'(n[i]);
      sq    += 132'(d[i]) * 132'(d[i]);
    end
    res = '{1'b0, '0, 1'b0};
    if (denom != 0 && (numer == 0 || (numer < 0) == (denom < 0))) begin
      res.hit = 1'b1;
      // truncated length of the direction
      root = '0;
      for (int b = 62; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        cand_sq = 128'(cand) * 128'(cand);
        if (cand_sq <= 128'(sq)) root = cand;
      end
      nmag = 256'(numer < 0 ? -numer : numer);
      dmag = 256'(denom < 0 ? -denom : denom);
      x = nmag * 256'(root);
      q = x / dmag;
      if (q >= (256'd1 << COORD_BITS)) begin
        res.distance  = '1;
        res.saturated = 1'b1;
      end else begin
        res.distance = q[COORD_BITS-1:0];
      end
    end
    return res;
  endfunction

  // coordinates biased towards small geometry, with extremes and noise
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom;
      5: return 32'($signed($urandom_range(0, 255)) - 128);
      default: return 32'($signed($urandom_range(0, 128 * 65536)) - 64 * 65536);
    endcase
  endfunction

  task automatic add_ray(input logic [COORD_BITS-1:0] ox, oy, oz, dx, dy, dz);
    ray_backlog.push_back('{ox, oy, oz, dx, dy, dz});
  endtask

  task automatic add_random_rays(input int count);
    for (int k = 0; k < count; k++)
      add_ray(pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord());
  endtask

  // plane registers go in back to back, then one write to an unused index
  task automatic load_plane(input logic [COORD_BITS-1:0] vals[6]);
    logic [CFG_IDX_W-1:0] idx[7];
    logic [COORD_BITS-1:0] dat[7];
    idx = '{REG_POINT_X, REG_POINT_Y, REG_POINT_Z, REG_NORMAL_X, REG_NORMAL_Y,
            REG_NORMAL_Z, ($urandom_range(0, 1) != 0) ? REG_UNUSED_HI : REG_UNUSED_LO};
    for (int i = 0; i < 6; i++) dat[i] = vals[i];
    dat[6] = $urandom;
    for (int i = 0; i < 7; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (ray_backlog.size() != 0 || in_valid || hits_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    if (phase < 2) begin
      send_idle_pct <= 7;
      recv_idle_pct <= 81;
    end else if (phase < 4) begin
      send_idle_pct <= 81;
      recv_idle_pct <= 7;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  endtask

  // ray sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (ray_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rpi_ray_t r;
        r = ray_backlog.pop_front();
        origin_x <= r.ox;
        origin_y <= r.oy;
        origin_z <= r.oz;
        dir_x    <= r.dx;
        dir_y    <= r.dy;
        dir_z    <= r.dz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // plane copy, prediction and checking
  always @(posedge clk) begin
    if (rst) begin
      plane_regs <= '{'0, '0, '0, '0, '0, NORMAL_Z_RESET};
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_NORMAL_Z)
        plane_regs[cfg_index] <= cfg_data;
      if (in_valid && in_ready)
        hits_due.push_back(trace_plane('{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z}));
      if (out_valid && out_ready) begin
        if (hits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: hit %0b distance %h saturated %0b",
                     hit, distance, saturated);
        end else begin
          ray_result_t want;
          want = hits_due.pop_front();
          if (hit !== want.hit || distance !== want.distance
              || saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit %0b distance %h saturated %0b, got %0b %h %0b",
                       want.hit, want.distance, want.saturated, hit, distance, saturated);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_plane_intersection regression: fail");
      $finish;
    end
  end

  initial begin
    logic [COORD_BITS-1:0] plane[6];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset plane z = 0 facing +z: parallel, behind, on plane, extremes
    set_idling(0);
    add_ray('0, '0, '0, '0, '0, '0);
    add_ray('0, '0, 32'h0001_0000, 32'h0001_0000, '0, '0);
    add_ray(32'h0003_0000, '0, '0, '0, 32'h0001_0000, 32'h0001_0000);
    add_ray('0, '0, 32'hffff_0000, '0, '0, 32'h0001_0000);
    add_ray('0, '0, 32'h0001_0000, '0, '0, 32'h0001_0000);
    add_ray('0, '0, 32'h0001_0000, '0, '0, 32'hffff_0000);
    add_ray('0, '0, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
    add_ray('0, '0, 32'h7fff_ffff, '0, '0, 32'hffff_ffff);
    add_ray('0, '0, 32'h8000_0000, '0, '0, 32'h0000_0001);
    add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, '0, 32'h0000_0001);
    add_ray('0, '0, 32'h8000_0000, '0, '0, 32'h7fff_ffff);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      set_idling(phase);
      case (phase)
        0: plane = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        1: plane = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        2: plane = '{'0, '0, '0, '0, '0, '0};
        default: for (int i = 0; i < 6; i++) plane[i] = pick_coord();
      endcase
      load_plane(plane);
      add_random_rays(phase == 2 ? 20 : 85);
      drain();
    end

    if (mismatches == 0) begin
      $display("ray_plane_intersection regression: pass");
    end else begin
      $display("ray_plane_intersection regression: fail");
    end
    $finish;
  end

endmodule
